/* hw/rtl/lzwde_pkg.sv */
// Shared types and constants of the LZW dictionary encoder.
`timescale 1ns / 1ps
`default_nettype none

package lzwde_pkg;

   localparam int CODE_W    = 12;
   localparam int BYTE_W    = 8;
   localparam int NFC_W     = 13;
   localparam int EPOCH_W   = 8;
   localparam int KEY_W     = CODE_W + BYTE_W;
   localparam int CODE_SPACE = 4096;

   localparam logic [NFC_W-1:0]   FIRST_FREE  = 13'd256;
   localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = 8'd0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_data;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last_code;
   } rsp_type;

   // One hash slot: owning stream epoch, the (prefix, byte) key and its code.
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [CODE_W-1:0]  prefix;
      logic [BYTE_W-1:0]  key_byte;
      logic [CODE_W-1:0]  code;
   } slot_type;

endpackage

`default_nettype wire

/* hw/rtl/lzwde_slot_ram.sv */
// Single-port-write, single-port-read hash slot memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lzwde_slot_ram #(
   parameter int ADDR_W = 13
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [ADDR_W-1:0]      wr_addr,
   input  wire lzwde_pkg::slot_type wr_data,
   input  wire                   rd_en,
   input  wire [ADDR_W-1:0]      rd_addr,
   output lzwde_pkg::slot_type   rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   lzwde_pkg::slot_type mem [DEPTH];
   lzwde_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/lzwde_rsp_queue.sv */
// Two-entry result queue between the encoder core and the rsp channel.
`timescale 1ns / 1ps
`default_nettype none

module lzwde_rsp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  wire lzwde_pkg::rsp_type push_data,
   output logic                space,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output lzwde_pkg::rsp_type  rsp_data
);

   lzwde_pkg::rsp_type ent_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       pop;
   logic       do_push;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = ent_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;
   assign do_push   = push & space;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      count_in  = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lzw_dictionary_encoder.sv */
// Top level of the LZW dictionary encoder with 12-bit codes.
`timescale 1ns / 1ps
`default_nettype none

// LZW encoder, 12-bit codes. Bytes enter on req_ (end_of_data marks the last
// byte of a stream); codes leave on rsp_, the final code of a stream with
// last_code set. The dictionary lives in a hash memory of 2^HASH_BITS slots
// (twice the code limit, rounded up to a power of two), probed linearly, one
// slot per cycle through the memory's single read port. Each slot carries the
// epoch of the stream that wrote it, so ending a stream costs nothing: the
// epoch advances and old slots read as empty. The first byte of a stream
// only starts the prefix; any later byte reads its hash slot, then one more
// slot per hash collision on its probe chain; a byte flagged last then
// passes through S_LAST, which emits the final code. Results queue in a
// 2-entry buffer, so a stalled rsp_ side holds the core only once two codes
// wait. After reset, and again after every 255 streams when the 8-bit epoch
// wraps, a clearing pass writes every slot (8192 at the default DICT_SIZE),
// during which req_ready stays low. DICT_SIZE caps the code space (at most
// 4096); once full the dictionary freezes until the end of the stream.

module lzw_dictionary_encoder #(
   parameter int DICT_SIZE = 4096
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire lzwde_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output lzwde_pkg::rsp_type  rsp_data
);

   localparam int CODE_LIMIT = (DICT_SIZE < lzwde_pkg::CODE_SPACE) ?
                               DICT_SIZE : lzwde_pkg::CODE_SPACE;
   localparam int HASH_BITS  = $clog2(CODE_LIMIT) + 1;
   localparam logic [lzwde_pkg::NFC_W-1:0] NFC_LIMIT = lzwde_pkg::NFC_W'(CODE_LIMIT);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;
   localparam logic [1:0] S_LAST  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [lzwde_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic                             last_ff, last_in;
   logic [lzwde_pkg::CODE_W-1:0]     prefix_ff, prefix_in;
   logic                             pvalid_ff, pvalid_in;
   logic [lzwde_pkg::NFC_W-1:0]      nfc_ff, nfc_in;
   logic [lzwde_pkg::EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [HASH_BITS-1:0]             idx_ff, idx_in;
   logic [HASH_BITS-1:0]             clr_idx_ff, clr_idx_in;

   logic                 wr_en;
   logic [HASH_BITS-1:0] wr_addr;
   lzwde_pkg::slot_type  wr_data;
   logic                 rd_en;
   logic [HASH_BITS-1:0] rd_addr;
   lzwde_pkg::slot_type  rd_data;

   logic                 push;
   lzwde_pkg::rsp_type   push_data;
   logic                 space;

   logic [HASH_BITS-1:0] hash_idx;
   logic [HASH_BITS-1:0] idx_step;
   logic                 slot_live;
   logic                 slot_hit;

   // Fold the 20-bit (prefix, byte) key onto the slot index width.
   always_comb begin
      logic [lzwde_pkg::KEY_W-1:0] key;
      key      = {prefix_ff, req_data.data_byte};
      hash_idx = '0;
      for (int i = 0; i < lzwde_pkg::KEY_W; i++) begin
         hash_idx[i % HASH_BITS] = hash_idx[i % HASH_BITS] ^ key[i];
      end
   end

   assign idx_step  = idx_ff + HASH_BITS'(1);
   assign slot_live = (rd_data.epoch == epoch_ff);
   assign slot_hit  = slot_live && (rd_data.prefix == prefix_ff) &&
                      (rd_data.key_byte == byte_ff);

   always_comb begin
      state_in   = state_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      prefix_in  = prefix_ff;
      pvalid_in  = pvalid_ff;
      nfc_in     = nfc_ff;
      epoch_in   = epoch_ff;
      idx_in     = idx_ff;
      clr_idx_in = clr_idx_ff;
      req_ready  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      push       = 1'b0;
      push_data  = '0;

      case (state_ff)
         S_CLEAR: begin
            // Sweep every slot back to the empty epoch.
            wr_en         = 1'b1;
            wr_addr       = clr_idx_ff;
            wr_data.epoch = lzwde_pkg::EPOCH_EMPTY;
            clr_idx_in    = clr_idx_ff + HASH_BITS'(1);
            if (clr_idx_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in = req_data.data_byte;
               last_in = req_data.end_of_data;
               if (!pvalid_ff) begin
                  // First byte of a stream only starts the prefix.
                  prefix_in = {{(lzwde_pkg::CODE_W - lzwde_pkg::BYTE_W){1'b0}},
                               req_data.data_byte};
                  pvalid_in = 1'b1;
                  state_in  = req_data.end_of_data ? S_LAST : S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = hash_idx;
                  idx_in   = hash_idx;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (slot_hit) begin
               prefix_in = rd_data.code;
               state_in  = last_ff ? S_LAST : S_IDLE;
            end else if (!slot_live) begin
               // Empty slot ends the chain: emit prefix and insert the pair unless the dictionary is full.
               if (space) begin
                  push                = 1'b1;
                  push_data.code      = prefix_ff;
                  push_data.last_code = 1'b0;
                  if (nfc_ff < NFC_LIMIT) begin
                     wr_en            = 1'b1;
                     wr_data.epoch    = epoch_ff;
                     wr_data.prefix   = prefix_ff;
                     wr_data.key_byte = byte_ff;
                     wr_data.code     = nfc_ff[lzwde_pkg::CODE_W-1:0];
                     nfc_in           = nfc_ff + lzwde_pkg::NFC_W'(1);
                  end
                  prefix_in = {{(lzwde_pkg::CODE_W - lzwde_pkg::BYTE_W){1'b0}}, byte_ff};
                  state_in  = last_ff ? S_LAST : S_IDLE;
               end
            end else begin
               // Collision: advance to the next slot.
               rd_en   = 1'b1;
               rd_addr = idx_step;
               idx_in  = idx_step;
            end
         end
         S_LAST: begin
            if (space) begin
               push                = 1'b1;
               push_data.code      = prefix_ff;
               push_data.last_code = 1'b1;
               nfc_in              = lzwde_pkg::FIRST_FREE;
               prefix_in           = '0;
               pvalid_in           = 1'b0;
               if (epoch_ff == lzwde_pkg::EPOCH_LAST) begin
                  epoch_in   = lzwde_pkg::EPOCH_FIRST;
                  clr_idx_in = '0;
                  state_in   = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + lzwde_pkg::EPOCH_W'(1);
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_idx_ff <= '0;
         epoch_ff   <= lzwde_pkg::EPOCH_FIRST;
         nfc_ff     <= lzwde_pkg::FIRST_FREE;
         prefix_ff  <= '0;
         pvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         epoch_ff   <= epoch_in;
         nfc_ff     <= nfc_in;
         prefix_ff  <= prefix_in;
         pvalid_ff  <= pvalid_in;
      end
   end

   // Hold the item payload and probe position.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   lzwde_slot_ram #(
      .ADDR_W (HASH_BITS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzwde_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
